FILE: rtl/fkr_pkg.sv
// Package for the keyed-removal FIFO: sizes, operation and status codes, cell control.
`default_nettype none
package fkr_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_FIND   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    logic pop;
    logic rmv;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/fkr_cell.sv
// One queue slot: holds a key, compares it, and shifts toward the head on pop or remove.
`default_nettype none
module fkr_cell (
  input  wire logic              clk,
  input  wire fkr_pkg::cell_ctl_t ctl,
  input  wire logic              occ,
  input  wire fkr_pkg::key_t     cmp_key,
  input  wire fkr_pkg::key_t     nb_key,
  input  wire logic              hit_in,
  output logic                   hit_out,
  output fkr_pkg::key_t          key_q
);
  import fkr_pkg::*;

  key_t key_r;
  key_t key_nxt;
  logic match;

  assign match   = occ && (key_r == cmp_key);
  assign hit_out = hit_in | match;
  assign key_q   = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctl.load) begin
      key_nxt = cmp_key;
    end else if (ctl.pop || (ctl.rmv && hit_out)) begin
      key_nxt = nb_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/fifo_with_keyed_removal_top.sv
// Top level of the keyed-removal FIFO: request decode, cell chain, fill count, result register.
//
// Ordered queue of nonzero keys held in a row of slot cells, slot 0 at the head. Each
// request (push, pop, remove by key, find) gives one registered result; a new
// request is taken every cycle unless the result register is full and stalled. All
// cells compare the key at once and a hit ripples toward the tail through the chain,
// so the first match from the head is removed and younger keys move up one slot in the
// same cycle. Reset empties the queue; slot contents need no clearing.
`default_nettype none
module fifo_with_keyed_removal_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_key,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_found,
  output logic [15:0]      out_out_key,
  output logic [4:0]       out_occupancy
);
  import fkr_pkg::*;

  logic      acc;
  func_t     func;
  key_t      cmp_key;
  logic      key_zero;
  cnt_t      cnt_r;
  cnt_t      cnt_nxt;
  logic      full;
  logic      empty;
  logic      found;
  logic      push_ok;
  logic      pop_ok;
  logic      rmv_ok;
  status_t   status;
  key_t      res_key;
  key_t      keys   [DEPTH];
  logic      hits   [DEPTH+1];

  logic        out_valid_r;
  logic [1:0]  status_r;
  logic        found_r;
  logic [15:0] out_key_r;
  logic [4:0]  occ_r;

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;
  assign func     = func_t'(in_func);
  assign cmp_key  = KEY_BITS'(in_key);
  assign key_zero = (cmp_key == '0);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign found    = hits[DEPTH];
  assign hits[0]  = 1'b0;

  assign push_ok = acc && (func == FN_PUSH) && !key_zero && !full;
  assign pop_ok  = acc && (func == FN_POP) && !empty;
  assign rmv_ok  = acc && (func == FN_REMOVE) && !key_zero && found;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      cell_ctl_t ctl;
      key_t      nb;
      assign ctl.load = push_ok && (cnt_r == CNT_W'(gi));
      assign ctl.pop  = pop_ok;
      assign ctl.rmv  = rmv_ok;
      if (gi == DEPTH - 1) begin : g_last
        assign nb = keys[gi];
      end else begin : g_mid
        assign nb = keys[gi+1];
      end
      fkr_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .occ     (CNT_W'(gi) < cnt_r),
        .cmp_key (cmp_key),
        .nb_key  (nb),
        .hit_in  (hits[gi]),
        .hit_out (hits[gi+1]),
        .key_q   (keys[gi])
      );
    end
  endgenerate

  always_comb begin
    status  = ST_OK;
    res_key = '0;
    cnt_nxt = cnt_r;
    case (func)
      FN_PUSH: begin
        if (key_zero) begin
          status = ST_INVALID;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      FN_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          res_key = keys[0];
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      FN_REMOVE: begin
        if (key_zero) begin
          status = ST_INVALID;
        end else if (found) begin
          res_key = cmp_key;
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          status = ST_EMPTY;
        end
      end
      FN_FIND: begin
        if (key_zero) begin
          status = ST_INVALID;
        end else if (!found) begin
          status = ST_EMPTY;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r  <= status;
      found_r   <= found && !key_zero &&
                   ((func == FN_REMOVE) || (func == FN_FIND));
      out_key_r <= 16'(res_key);
      occ_r     <= 5'(cnt_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_found     = found_r;
  assign out_out_key   = out_key_r;
  assign out_occupancy = occ_r;

endmodule
`default_nettype wire
